// ===== hdl/fpas_pkg.sv =====
// ----------------------------------------------------------------------------
// fpas_pkg
// Shared types and constants for the single-precision add/subtract pipeline.
// ----------------------------------------------------------------------------
package fpas_pkg;

   localparam int FracW   = 23;
   localparam int ExpW    = 8;
   localparam int GuardW  = 26;
   // width of the aligned significand: carry bit, hidden bit, fraction and guard bits
   localparam int SumW    = FracW + 1 + GuardW + 1;
   localparam int PosW    = 6;
   localparam logic [31:0] QnanBits = 32'h7FC0_0000;
   localparam logic [ExpW-1:0] ExpMax = 8'hFF;

   // aligned operands, handed from the align stage to the add stage
   typedef struct packed {
      logic              special;
      logic [31:0]       special_bits;
      logic              sign_l;
      logic              eff_sub;
      logic [ExpW-1:0]   exp_l;
      logic [SumW-1:0]   big;
      logic [SumW-1:0]   lesser;
   } align_type;

   // raw sum with its leading-one position, handed to the round stage
   typedef struct packed {
      logic              special;
      logic [31:0]       special_bits;
      logic              sign_l;
      logic [ExpW-1:0]   exp_l;
      logic [SumW-1:0]   sum;
      logic [PosW-1:0]   pos;
   } sum_type;

endpackage

// ===== hdl/fpas_align.sv =====
// ----------------------------------------------------------------------------
// fpas_align
// Operand decode, special-case detect, swap and sticky alignment shift.
// ----------------------------------------------------------------------------
module fpas_align (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  logic [31:0]         a_bits,
   input  logic [31:0]         b_bits,
   input  logic                opcode,
   output logic                out_valid,
   output fpas_pkg::align_type out_word
);
   import fpas_pkg::*;

   logic [31:0]     b_eff;
   logic            sa, sb, a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
   logic [ExpW-1:0] ea, eb, es;
   logic [30:0]     ma, mb;
   logic [FracW:0]  gl, gs;
   logic [ExpW-1:0] d;
   logic [SumW-1:0] small_full, small_sh, sh_mask;
   logic            sticky;
   align_type       word_in, word_ff;
   logic            valid_ff;

   always_comb begin
      b_eff  = {b_bits[31] ^ opcode, b_bits[30:0]};
      sa     = a_bits[31];
      sb     = b_eff[31];
      ea     = a_bits[30:23];
      eb     = b_eff[30:23];
      a_nan  = (ea == ExpMax) && (a_bits[22:0] != '0);
      b_nan  = (eb == ExpMax) && (b_eff[22:0] != '0);
      a_inf  = (ea == ExpMax) && (a_bits[22:0] == '0);
      b_inf  = (eb == ExpMax) && (b_eff[22:0] == '0);
      a_zero = (ea == '0);
      b_zero = (eb == '0);
      ma     = a_zero ? '0 : a_bits[30:0];
      mb     = b_zero ? '0 : b_eff[30:0];

      word_in = '0;
      word_in.special = 1'b1;
      if (a_nan || b_nan || (a_inf && b_inf && (sa != sb))) begin
         word_in.special_bits = QnanBits;
      end else if (a_inf) begin
         word_in.special_bits = {sa, ExpMax, 23'd0};
      end else if (b_inf) begin
         word_in.special_bits = {sb, ExpMax, 23'd0};
      end else if (a_zero && b_zero) begin
         word_in.special_bits = {sa & sb, 31'd0};
      end else begin
         word_in.special = 1'b0;
      end

      if (ma >= mb) begin
         word_in.sign_l  = sa;
         word_in.exp_l   = ea;
         gl              = {1'b1, a_bits[22:0]};
         gs              = b_zero ? '0 : {1'b1, b_eff[22:0]};
         es              = eb;
         word_in.eff_sub = sa ^ sb;
      end else begin
         word_in.sign_l  = sb;
         word_in.exp_l   = eb;
         gl              = {1'b1, b_eff[22:0]};
         gs              = a_zero ? '0 : {1'b1, a_bits[22:0]};
         es              = ea;
         word_in.eff_sub = sa ^ sb;
      end
      d = (gs == '0) ? '0 : word_in.exp_l - es;

      word_in.big = {1'b0, gl, {GuardW{1'b0}}};
      small_full  = {1'b0, gs, {GuardW{1'b0}}};
      if (d >= ExpW'(SumW)) begin
         small_sh = '0;
         sh_mask  = '0;
         sticky   = (small_full != '0);
      end else begin
         small_sh = small_full >> d;
         sh_mask  = ~({SumW{1'b1}} << d);
         sticky   = (small_full & sh_mask) != '0;
      end
      word_in.lesser = small_sh | {{(SumW-1){1'b0}}, sticky};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      word_ff <= word_in;
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;
endmodule

// ===== hdl/fpas_add.sv =====
// ----------------------------------------------------------------------------
// fpas_add
// Significand add or subtract and leading-one position.
// ----------------------------------------------------------------------------
module fpas_add (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  fpas_pkg::align_type in_word,
   output logic                out_valid,
   output fpas_pkg::sum_type   out_word
);
   import fpas_pkg::*;

   sum_type word_in, word_ff;
   logic    valid_ff;

   always_comb begin
      word_in              = '0;
      word_in.special      = in_word.special;
      word_in.special_bits = in_word.special_bits;
      word_in.sign_l       = in_word.sign_l;
      word_in.exp_l        = in_word.exp_l;
      word_in.sum = in_word.eff_sub ? in_word.big - in_word.lesser
                                    : in_word.big + in_word.lesser;
      // priority search, independent bit compares
      for (int i = 0; i < SumW; i++) begin
         if (word_in.sum[i]) word_in.pos = PosW'(i);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      word_ff <= word_in;
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;
endmodule

// ===== hdl/fpas_round.sv =====
// ----------------------------------------------------------------------------
// fpas_round
// Normalize shift, round to nearest even, underflow flush and overflow.
// ----------------------------------------------------------------------------
module fpas_round (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  fpas_pkg::sum_type in_word,
   output logic              out_valid,
   output logic [31:0]       out_bits
);
   import fpas_pkg::*;

   logic [PosW-1:0] sh;
   logic [SumW-1:0] norm, rem_mask, rem, half;
   logic [FracW+1:0] mant;
   logic signed [10:0] e;
   logic [31:0]     bits_in, bits_ff;
   logic            valid_ff;

   always_comb begin
      sh       = in_word.pos - PosW'(FracW);
      norm     = in_word.sum >> sh;
      rem_mask = ~({SumW{1'b1}} << sh);
      rem      = in_word.sum & rem_mask;
      half     = {{(SumW-1){1'b0}}, 1'b1} << (sh - PosW'(1));
      mant     = {1'b0, norm[FracW:0]};
      e = 11'(signed'({1'b0, in_word.exp_l})) + 11'(signed'({1'b0, in_word.pos}))
          - 11'(FracW + GuardW);
      if (in_word.special) begin
         bits_in = in_word.special_bits;
      end else if (in_word.sum == '0) begin
         bits_in = '0;
      end else if (e <= 0) begin
         bits_in = {in_word.sign_l, 31'd0};
      end else begin
         if ((rem > half) || ((rem == half) && mant[0])) mant = mant + 1'b1;
         if (mant[FracW+1]) begin
            mant = mant >> 1;
            e    = e + 11'sd1;
         end
         if (e >= 11'sd255) bits_in = {in_word.sign_l, ExpMax, 23'd0};
         else bits_in = {in_word.sign_l, e[ExpW-1:0], mant[FracW-1:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      bits_ff <= bits_in;
   end

   assign out_valid = valid_ff;
   assign out_bits  = bits_ff;
endmodule

// ===== hdl/fp32_add_sub_top.sv =====
// rsp_strobe follows start through the align, add and round stage registers
// throughput: one word per cycle, busy is always low
// the receiver cannot stall, so the pipeline never holds
// reset: synchronous, active high, clears the stage valid bits only
// ----------------------------------------------------------------------------
// fp32_add_sub_top
// Single-precision add/subtract, three-stage pipeline.
// ----------------------------------------------------------------------------
module fp32_add_sub_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_a_bits,
   input  logic [31:0] req_b_bits,
   input  logic        req_opcode,
   output logic        rsp_strobe,
   output logic [31:0] rsp_result_bits
);
   import fpas_pkg::*;

   logic      v1, v2;
   align_type w1;
   sum_type   w2;

   assign busy = 1'b0;

   fpas_align u_align (
      .clock(clock), .reset(reset), .in_valid(start),
      .a_bits(req_a_bits), .b_bits(req_b_bits), .opcode(req_opcode),
      .out_valid(v1), .out_word(w1)
   );

   fpas_add u_add (
      .clock(clock), .reset(reset), .in_valid(v1), .in_word(w1),
      .out_valid(v2), .out_word(w2)
   );

   fpas_round u_round (
      .clock(clock), .reset(reset), .in_valid(v2), .in_word(w2),
      .out_valid(rsp_strobe), .out_bits(rsp_result_bits)
   );
endmodule

// ===== hdl/fpas_checker.sv =====
// ----------------------------------------------------------------------------
// fpas_checker
// Port-level checks for the add/subtract pipeline.
// ----------------------------------------------------------------------------
module fpas_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_strobe,
   input logic [31:0] rsp_result_bits
);
   a_latency: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##3 rsp_strobe) else $error("missing response");
   a_no_extra: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start, 3)) else $error("unexpected response");
   a_never_busy: assert property (@(posedge clock) !busy)
      else $error("busy raised");
   a_result_known: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !$isunknown(rsp_result_bits)) else $error("unknown result");
endmodule

bind fp32_add_sub_top fpas_checker u_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_strobe(rsp_strobe), .rsp_result_bits(rsp_result_bits)
);

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the single-precision add/subtract pipeline: operand pairs are driven
// through the start/busy handshake with random gaps, each sum is predicted by
// a bit-exact software model and compared with the strobed result in order.
// ----------------------------------------------------------------------------
module tb_top;

   localparam logic OP_ADD = 1'b0;
   localparam logic OP_SUB = 1'b1;
   localparam logic [31:0] QNAN = 32'h7FC0_0000;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [31:0] req_a_bits;
   logic [31:0] req_b_bits;
   logic        req_opcode;
   logic        rsp_strobe;
   logic [31:0] rsp_result_bits;

   logic [31:0] sum_queue[$];
   int          errors;
   int          words_sent;
   int          words_checked;

   fp32_add_sub_top dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_a_bits(req_a_bits),
      .req_b_bits(req_b_bits),
      .req_opcode(req_opcode),
      .rsp_strobe(rsp_strobe),
      .rsp_result_bits(rsp_result_bits)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic int unsigned top_bit(logic [63:0] v);
      int unsigned p;
      p = 0;
      for (int i = 0; i < 64; i++) begin
         if (v[i]) p = i;
      end
      return p;
   endfunction

   function automatic logic [31:0] fp_sum(logic [31:0] a, logic [31:0] b, logic op);
      logic        sa, sb, sl, ss;
      logic [7:0]  ea, eb, el, es;
      logic [22:0] fa, fb;
      logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
      logic [30:0] ma, mb;
      logic [23:0] gl, gs;
      logic [63:0] big, sml, total, mant, rem, half;
      int unsigned d, p, sh;
      int          e;
      logic        sticky;
      if (op) b[31] = ~b[31];
      sa = a[31]; sb = b[31];
      ea = a[30:23]; eb = b[30:23];
      fa = a[22:0]; fb = b[22:0];
      a_nan = (ea == 8'hFF) && (fa != 0);
      b_nan = (eb == 8'hFF) && (fb != 0);
      a_inf = (ea == 8'hFF) && (fa == 0);
      b_inf = (eb == 8'hFF) && (fb == 0);
      a_zero = (ea == 0);
      b_zero = (eb == 0);
      if (a_nan || b_nan || (a_inf && b_inf && sa != sb)) return QNAN;
      if (a_inf) return {sa, 8'hFF, 23'd0};
      if (b_inf) return {sb, 8'hFF, 23'd0};
      if (a_zero && b_zero) return {sa & sb, 31'd0};
      ma = a_zero ? 31'd0 : a[30:0];
      mb = b_zero ? 31'd0 : b[30:0];
      if (ma >= mb) begin
         sl = sa; el = ea; gl = {1'b1, fa};
         ss = sb; es = eb; gs = b_zero ? 24'd0 : {1'b1, fb};
      end else begin
         sl = sb; el = eb; gl = {1'b1, fb};
         ss = sa; es = ea; gs = a_zero ? 24'd0 : {1'b1, fa};
      end
      d = (gs == 0) ? 0 : int'(el) - int'(es);
      big = 64'(gl) << 26;
      sml = 64'(gs) << 26;
      if (d >= 64) begin
         sml = (sml != 0) ? 64'd1 : 64'd0;
      end else if (d > 0) begin
         sticky = (sml & ((64'd1 << d) - 1)) != 0;
         sml = (sml >> d) | 64'(sticky);
      end
      total = (sl == ss) ? big + sml : big - sml;
      if (total == 0) return 32'd0;
      p = top_bit(total);
      e = int'(el) + int'(p) - 49;
      sh = p - 23;
      mant = total >> sh;
      rem = total & ((64'd1 << sh) - 1);
      half = 64'd1 << (sh - 1);
      if (e <= 0) return {sl, 31'd0};
      if (rem > half || (rem == half && mant[0])) mant++;
      if (mant >= (64'd1 << 24)) begin
         mant = mant >> 1;
         e++;
      end
      if (e >= 255) return {sl, 8'hFF, 23'd0};
      return {sl, e[7:0], mant[22:0]};
   endfunction

   // mostly short gaps, now and then a long one
   task automatic idle_gap();
      int n;
      n = ($urandom_range(0, 9) < 6) ? 0 :
          ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(5, 25);
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(negedge clock);
      end
   endtask

   task automatic send_word(logic [31:0] a, logic [31:0] b, logic op, bit gaps);
      if (gaps) idle_gap();
      start      <= 1'b1;
      req_a_bits <= a;
      req_b_bits <= b;
      req_opcode <= op;
      do @(posedge clock); while (busy);
      sum_queue.push_back(fp_sum(a, b, op));
      words_sent++;
      @(negedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (sum_queue.size() == 0) begin
            $display("%0t: unexpected word, actual %h", $time, rsp_result_bits);
            errors++;
         end else begin
            if (rsp_result_bits !== sum_queue[0]) begin
               $display("%0t: result_bits mismatch, expected %h actual %h",
                        $time, sum_queue[0], rsp_result_bits);
               errors++;
            end
            void'(sum_queue.pop_front());
            words_checked++;
         end
      end
   end

   function automatic logic [31:0] rand_float();
      logic [7:0] e;
      logic [22:0] f;
      case ($urandom_range(0, 9))
         0: e = 8'h00;
         1: e = 8'hFF;
         2: e = $urandom_range(0, 1) ? 8'h01 : 8'hFE;
         default: e = 8'($urandom_range(1, 254));
      endcase
      f = 23'($urandom);
      if (e == 8'hFF && $urandom_range(0, 1)) f = 0;
      if ($urandom_range(0, 7) == 0) f = $urandom_range(0, 1) ? 23'd0 : 23'h7FFFFF;
      return {1'($urandom), e, f};
   endfunction

   task automatic test_directed();
      logic [31:0] vals[12];
      vals = '{32'h0000_0000, 32'h8000_0000, 32'h0000_0001, 32'h7F80_0000,
               32'hFF80_0000, 32'h7FC0_0000, 32'hFFFF_FFFF, 32'h7F7F_FFFF,
               32'h0080_0000, 32'h3F80_0000, 32'hBF80_0000, 32'h3380_0000};
      send_word(32'h8000_0000, 32'h8000_0000, OP_ADD, 0);
      send_word(32'h8000_0000, 32'h0000_0000, OP_SUB, 0);
      send_word(32'h7F80_0000, 32'h7F80_0000, OP_SUB, 0);
      send_word(32'h7F80_0000, 32'hFF80_0000, OP_ADD, 0);
      send_word(32'h3F80_0000, 32'h3F80_0000, OP_SUB, 0);
      send_word(32'h7F7F_FFFF, 32'h7F7F_FFFF, OP_ADD, 0);
      send_word(32'h0080_0001, 32'h0080_0000, OP_SUB, 0);
      send_word(32'h3F80_0000, 32'h3380_0000, OP_ADD, 0);
      send_word(32'h3F80_0001, 32'h3380_0000, OP_ADD, 0);
      send_word(32'h3F80_0000, 32'h0000_0001, OP_SUB, 0);
      send_word(32'h7FFF_FFFF, 32'h3F80_0000, OP_ADD, 0);
      for (int i = 0; i < 12; i++)
         send_word(vals[i], vals[(i * 5 + 3) % 12], 1'(i), i > 6);
   endtask

   task automatic test_random(int count);
      logic [31:0] a, b;
      for (int i = 0; i < count; i++) begin
         a = rand_float();
         if ($urandom_range(0, 3) == 0) begin
            // nearby exponent, exercises cancellation and rounding
            b = {1'($urandom), a[30:23] + 8'($urandom_range(0, 2)) - 8'd1, 23'($urandom)};
            if ($urandom_range(0, 3) == 0) b = a ^ 32'h8000_0000 ^ 32'($urandom_range(0, 3));
         end else if ($urandom_range(0, 9) == 0) begin
            b = $urandom;
         end else begin
            b = rand_float();
         end
         send_word(a, b, 1'($urandom), $urandom_range(0, 99) >= 15);
      end
   endtask

   initial begin
      int waited;
      errors = 0;
      words_sent = 0;
      words_checked = 0;
      reset = 1'b1;
      start = 1'b0;
      req_a_bits = '0;
      req_b_bits = '0;
      req_opcode = OP_ADD;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_random(1750);
      start <= 1'b0;
      waited = 0;
      while (sum_queue.size() != 0 && waited < 1000) begin
         @(posedge clock);
         waited++;
      end
      repeat (6) @(posedge clock);
      $display("sent %0d words, checked %0d results", words_sent, words_checked);
      $display("covered zeros, subnormals, infinities, nans, cancellation and overflow");
      if (errors == 0 && sum_queue.size() == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("tb_top: done, errors");
      $finish;
   end

endmodule
